>>> src/becke_cell_weight_top_defines.svh
// Assertion macros for the Becke cell weight block
`ifndef BECKE_CELL_WEIGHT_TOP_DEFINES_SVH
`define BECKE_CELL_WEIGHT_TOP_DEFINES_SVH

// Implication checked in the same cycle
`define BCW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the following cycle
`define BCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/bcw_pkg.sv
// Shared types and constants for the Becke cell weight block
`timescale 1ns / 1ps
`default_nettype none
package bcw_pkg;

  localparam int DEF_MAX_ATOMS    = 64;
  localparam int DEF_SMOOTH_STEPS = 3;

  localparam int COORD_W  = 32;
  localparam int ATOM_W   = 3 * COORD_W;
  localparam int CNT_W    = 7;
  localparam int IDX_W    = 6;
  localparam int DIFF_W   = 33;
  localparam int SQ_W     = 66;
  localparam int DIST_W   = 33;
  localparam int DIV_W    = 38;
  localparam int Q_W      = 31;
  localparam int STEP_W   = 5;
  localparam int P_W      = 32;
  localparam int SUM_W    = 38;
  localparam int WEIGHT_W = 25;
  localparam int MUL_W    = 33;
  localparam int PROD_W   = 66;

  localparam int MU_STEPS = 30;
  localparam int WT_STEPS = 24;

  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam logic [PADDR_W-1:0] ADDR_ATOM_COUNT = 3'd0;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PD_RD,
    ST_PD_LAT,
    ST_DS_MUL,
    ST_DS_ACC,
    ST_DS_SQ,
    ST_PK_RD,
    ST_PK_LAT,
    ST_PJ_CHK,
    ST_PJ_LAT,
    ST_MU,
    ST_SM1,
    ST_SM2,
    ST_SM3,
    ST_PF,
    ST_PF2,
    ST_PK_END,
    ST_FIN,
    ST_WT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [DIV_W-1:0]  den;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage
`default_nettype wire

>>> src/bcw_ram.sv
// Generic single write, single registered read RAM
`timescale 1ns / 1ps
`default_nettype none
module bcw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/bcw_mul.sv
// Shared registered unsigned multiplier
`timescale 1ns / 1ps
`default_nettype none
module bcw_mul import bcw_pkg::*; (
  input  wire logic              clk,
  input  wire logic [MUL_W-1:0]  a,
  input  wire logic [MUL_W-1:0]  b,
  output logic      [PROD_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end

endmodule
`default_nettype wire

>>> src/bcw_sqrt.sv
// Bit-serial floor square root, one result bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module bcw_sqrt import bcw_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SQ_W-1:0]   value,
  output logic                   done_r,
  output logic      [DIST_W-1:0] root
);

  logic [SQ_W-1:0] op_r, res_r, one_r;
  logic            busy_r;
  logic [SQ_W-1:0] trial;

  assign trial = res_r + one_r;
  assign root  = res_r[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        op_r   <= value;
        res_r  <= '0;
        one_r  <= SQ_W'(1) << (SQ_W - 2);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (op_r >= trial) begin
          op_r  <= op_r - trial;
          res_r <= (res_r >> 1) + one_r;
        end else begin
          res_r <= res_r >> 1;
        end
        one_r <= one_r >> 2;
        if ((one_r >> 2) == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> src/bcw_div.sv
// Restoring fractional divider: floor(num * 2^steps / den), saturating at one
`timescale 1ns / 1ps
`default_nettype none
module bcw_div import bcw_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire div_req_t       req,
  output logic                done_r,
  output logic      [Q_W-1:0] q_r
);

  logic [DIV_W:0]    rem_r;
  logic [DIV_W-1:0]  den_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic [DIV_W:0]    shifted;

  assign shifted = {rem_r[DIV_W-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        den_r <= req.den;
        if (req.num >= req.den) begin
          q_r    <= Q_W'(1) << req.steps;
          done_r <= 1'b1;
        end else begin
          rem_r  <= {1'b0, req.num};
          q_r    <= '0;
          cnt_r  <= req.steps;
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        if (shifted >= {1'b0, den_r}) begin
          rem_r <= shifted - {1'b0, den_r};
          q_r   <= {q_r[Q_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted;
          q_r   <= {q_r[Q_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> src/becke_cell_weight_top.sv
// Top level of the Becke fuzzy cell partition weight block
`timescale 1ns / 1ps
`default_nettype none
`include "becke_cell_weight_top_defines.svh"
// Becke cell weight. A load (in_kind 0) writes one atom position into the
// store and gives no result; busy stays low. A query (in_kind 1) raises
// busy and returns one result, weight in unsigned Q1.24 plus an error flag,
// on out_weight/out_error for exactly one cycle marked by out_valid; the
// receiver cannot stall, so sample it then. Each point distance takes three
// squares through the shared multiplier, then a serial square root. Each
// ordered atom pair takes its separation as above, a serial division for
// mu, the smoothing steps and a product update; the division ends at once
// when mu saturates. Each atom's product then adds to the sum, and a final
// division gives the weight. The result strobe rises in the same cycle that
// busy drops. Out of range queries skip all of this and answer from the
// done state; coincident atoms end the query at the first such pair, after
// the point distances. Both give weight 0 and the error flag. atom_count is
// written over the APB port; the user must write it only while the block
// is idle, which the block itself does not enforce. Reads return it.
module becke_cell_weight_top import bcw_pkg::*; #(
  parameter int MAX_ATOMS    = DEF_MAX_ATOMS,
  parameter int SMOOTH_STEPS = DEF_SMOOTH_STEPS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                in_kind,
  input  wire logic [IDX_W-1:0]    in_atom_index,
  input  wire logic [COORD_W-1:0]  in_coord_x,
  input  wire logic [COORD_W-1:0]  in_coord_y,
  input  wire logic [COORD_W-1:0]  in_coord_z,
  output logic                     out_valid,
  output logic [WEIGHT_W-1:0]      out_weight,
  output logic                     out_error,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  localparam int AW   = $clog2(MAX_ATOMS);
  localparam int SM_W = $clog2(SMOOTH_STEPS + 1);

  // Config register
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] n_lim;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ATOM_COUNT) ? PDATA_W'(count_r) : '0;
  assign n_lim  = (32'(count_r) > MAX_ATOMS) ? CNT_W'(MAX_ATOMS) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(1);
    end else if (psel && penable && pwrite && paddr == ADDR_ATOM_COUNT) begin
      count_r <= pwdata[CNT_W-1:0];
    end
  end

  // Sequencer state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt, j_r, j_nxt, n_r, n_nxt, idx_r, idx_nxt;
  logic [1:0]        ax_r, ax_nxt;
  logic [SM_W-1:0]   sm_r, sm_nxt;
  logic              pair_r, pair_nxt;
  logic [ATOM_W-1:0] pt_r, pt_nxt, opa_r, opa_nxt, opb_r, opb_nxt, ak_r, ak_nxt;
  logic [SQ_W-1:0]   acc_r, acc_nxt;
  logic [DIST_W-1:0] dk_r, dk_nxt, mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic [Q_W-1:0]    m_r, m_nxt;
  logic [P_W-1:0]    pk_r, pk_nxt, pn_r, pn_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [WEIGHT_W-1:0] resw_r, resw_nxt;
  logic              rese_r, rese_nxt;
  logic              outv_r, outv_nxt;

  // Memories and shared units
  logic              atom_we;
  logic [AW-1:0]     atom_waddr, atom_raddr, pd_waddr, pd_raddr;
  logic [ATOM_W-1:0] atom_rdata;
  logic              pd_we;
  logic [DIST_W-1:0] pd_rdata;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic              sq_start, sq_done;
  logic [DIST_W-1:0] sq_root;
  div_req_t          dreq;
  logic              div_done;
  logic [Q_W-1:0]    div_q;

  bcw_ram #(.WIDTH(ATOM_W), .DEPTH(MAX_ATOMS)) u_atom_ram (
    .clk(clk), .we(atom_we), .waddr(atom_waddr),
    .wdata({in_coord_x, in_coord_y, in_coord_z}),
    .raddr(atom_raddr), .rdata_r(atom_rdata)
  );

  // Distance of the grid point to every atom in use
  bcw_ram #(.WIDTH(DIST_W), .DEPTH(MAX_ATOMS)) u_pd_ram (
    .clk(clk), .we(pd_we), .waddr(pd_waddr), .wdata(sq_root),
    .raddr(pd_raddr), .rdata_r(pd_rdata)
  );

  bcw_mul  u_mul  (.clk(clk), .a(mul_a), .b(mul_b), .prod_r(prod));

  bcw_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .value(acc_nxt),
    .done_r(sq_done), .root(sq_root)
  );

  bcw_div  u_div  (.clk(clk), .rst_n(rst_n), .req(dreq), .done_r(div_done), .q_r(div_q));

  // Absolute coordinate difference on the current axis (x is the top word)
  logic [COORD_W-1:0] ca, cb;
  logic [DIFF_W-1:0]  sdiff, absd;
  logic [DIFF_W:0]    m3x;
  logic [Q_W-1:0]     m3;
  logic [P_W-1:0]     sfac;

  always_comb begin
    case (ax_r)
      2'd0:    begin ca = opa_r[3*COORD_W-1:2*COORD_W]; cb = opb_r[3*COORD_W-1:2*COORD_W]; end
      2'd1:    begin ca = opa_r[2*COORD_W-1:COORD_W];   cb = opb_r[2*COORD_W-1:COORD_W];   end
      default: begin ca = opa_r[COORD_W-1:0];           cb = opb_r[COORD_W-1:0];           end
    endcase
  end

  assign sdiff = {ca[COORD_W-1], ca} - {cb[COORD_W-1], cb};
  assign absd  = sdiff[DIFF_W-1] ? (~sdiff + DIFF_W'(1)) : sdiff;
  assign m3    = prod[60:30];
  // 3m - m^3, never negative since m is at most one
  assign m3x   = {3'b000, m_r} + {2'b00, m_r, 1'b0} - {3'b000, m3};
  assign sfac  = neg_r ? (P_W'(1) << 30) + P_W'(m_r) : (P_W'(1) << 30) - P_W'(m_r);

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    k_nxt = k_r;  j_nxt = j_r;  n_nxt = n_r;  idx_nxt = idx_r;
    ax_nxt = ax_r;  sm_nxt = sm_r;  pair_nxt = pair_r;
    pt_nxt = pt_r;  opa_nxt = opa_r;  opb_nxt = opb_r;  ak_nxt = ak_r;
    acc_nxt = acc_r;  dk_nxt = dk_r;  mag_nxt = mag_r;  neg_nxt = neg_r;
    m_nxt = m_r;  pk_nxt = pk_r;  pn_nxt = pn_r;  sum_nxt = sum_r;
    resw_nxt = resw_r;  rese_nxt = rese_r;  outv_nxt = 1'b0;
    atom_we = 1'b0;  atom_waddr = AW'(in_atom_index);
    atom_raddr = AW'(k_r);  pd_raddr = AW'(k_r);
    pd_we = 1'b0;  pd_waddr = AW'(k_r);
    mul_a = '0;  mul_b = '0;
    sq_start = 1'b0;
    dreq = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (!in_kind) begin
            atom_we = (32'(in_atom_index) < MAX_ATOMS);
          end else begin
            n_nxt   = n_lim;
            idx_nxt = CNT_W'(in_atom_index);
            pt_nxt  = {in_coord_x, in_coord_y, in_coord_z};
            k_nxt   = '0;
            sum_nxt = '0;
            pn_nxt  = '0;
            if (n_lim == '0 || CNT_W'(in_atom_index) >= n_lim) begin
              resw_nxt  = '0;
              rese_nxt  = 1'b1;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_PD_RD;
            end
          end
        end
      end
      ST_PD_RD: begin
        state_nxt = ST_PD_LAT;
      end
      ST_PD_LAT: begin
        opa_nxt   = pt_r;
        opb_nxt   = atom_rdata;
        pair_nxt  = 1'b0;
        acc_nxt   = '0;
        ax_nxt    = '0;
        state_nxt = ST_DS_MUL;
      end
      ST_DS_MUL: begin
        mul_a     = absd;
        mul_b     = absd;
        state_nxt = ST_DS_ACC;
      end
      ST_DS_ACC: begin
        acc_nxt = acc_r + prod;
        if (ax_r == 2'd2) begin
          sq_start  = 1'b1;
          state_nxt = ST_DS_SQ;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = ST_DS_MUL;
        end
      end
      ST_DS_SQ: begin
        if (sq_done) begin
          if (!pair_r) begin
            pd_we = 1'b1;
            if (k_r + CNT_W'(1) == n_r) begin
              k_nxt     = '0;
              state_nxt = ST_PK_RD;
            end else begin
              k_nxt     = k_r + CNT_W'(1);
              state_nxt = ST_PD_RD;
            end
          end else if (sq_root == '0) begin
            resw_nxt  = '0;
            rese_nxt  = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            dreq.start = 1'b1;
            dreq.num   = DIV_W'(mag_r);
            dreq.den   = DIV_W'(sq_root);
            dreq.steps = STEP_W'(MU_STEPS);
            state_nxt  = ST_MU;
          end
        end
      end
      ST_PK_RD: begin
        state_nxt = ST_PK_LAT;
      end
      ST_PK_LAT: begin
        ak_nxt    = atom_rdata;
        dk_nxt    = pd_rdata;
        pk_nxt    = P_W'(1) << 31;
        j_nxt     = '0;
        state_nxt = ST_PJ_CHK;
      end
      ST_PJ_CHK: begin
        atom_raddr = AW'(j_r);
        pd_raddr   = AW'(j_r);
        if (j_r == n_r) begin
          state_nxt = ST_PK_END;
        end else if (j_r == k_r) begin
          j_nxt = j_r + CNT_W'(1);
        end else begin
          state_nxt = ST_PJ_LAT;
        end
      end
      ST_PJ_LAT: begin
        opa_nxt   = ak_r;
        opb_nxt   = atom_rdata;
        neg_nxt   = dk_r < pd_rdata;
        mag_nxt   = (dk_r < pd_rdata) ? pd_rdata - dk_r : dk_r - pd_rdata;
        pair_nxt  = 1'b1;
        acc_nxt   = '0;
        ax_nxt    = '0;
        state_nxt = ST_DS_MUL;
      end
      ST_MU: begin
        if (div_done) begin
          m_nxt     = div_q;
          sm_nxt    = '0;
          state_nxt = ST_SM1;
        end
      end
      ST_SM1: begin
        mul_a     = MUL_W'(m_r);
        mul_b     = MUL_W'(m_r);
        state_nxt = ST_SM2;
      end
      ST_SM2: begin
        mul_a     = MUL_W'(prod[60:30]);
        mul_b     = MUL_W'(m_r);
        state_nxt = ST_SM3;
      end
      ST_SM3: begin
        m_nxt = m3x[Q_W:1];
        if (sm_r == SM_W'(SMOOTH_STEPS - 1)) begin
          state_nxt = ST_PF;
        end else begin
          sm_nxt    = sm_r + SM_W'(1);
          state_nxt = ST_SM1;
        end
      end
      ST_PF: begin
        mul_a     = MUL_W'(pk_r);
        mul_b     = MUL_W'(sfac);
        state_nxt = ST_PF2;
      end
      ST_PF2: begin
        pk_nxt    = prod[62:31];
        j_nxt     = j_r + CNT_W'(1);
        state_nxt = ST_PJ_CHK;
      end
      ST_PK_END: begin
        sum_nxt = sum_r + SUM_W'(pk_r);
        if (k_r == idx_r) begin
          pn_nxt = pk_r;
        end
        if (k_r + CNT_W'(1) == n_r) begin
          state_nxt = ST_FIN;
        end else begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = ST_PK_RD;
        end
      end
      ST_FIN: begin
        if (sum_r == '0) begin
          resw_nxt  = '0;
          rese_nxt  = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          dreq.start = 1'b1;
          dreq.num   = DIV_W'(pn_r);
          dreq.den   = sum_r;
          dreq.steps = STEP_W'(WT_STEPS);
          state_nxt  = ST_WT;
        end
      end
      ST_WT: begin
        if (div_done) begin
          resw_nxt  = div_q[WEIGHT_W-1:0];
          rese_nxt  = 1'b0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        outv_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      outv_r  <= outv_nxt;
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    k_r <= k_nxt;  j_r <= j_nxt;  n_r <= n_nxt;  idx_r <= idx_nxt;
    ax_r <= ax_nxt;  sm_r <= sm_nxt;  pair_r <= pair_nxt;
    pt_r <= pt_nxt;  opa_r <= opa_nxt;  opb_r <= opb_nxt;  ak_r <= ak_nxt;
    acc_r <= acc_nxt;  dk_r <= dk_nxt;  mag_r <= mag_nxt;  neg_r <= neg_nxt;
    m_r <= m_nxt;  pk_r <= pk_nxt;  pn_r <= pn_nxt;  sum_r <= sum_nxt;
    resw_r <= resw_nxt;  rese_r <= rese_nxt;
  end

  // Result transfer: one cycle, cannot be held off
  assign out_valid  = outv_r;
  assign out_weight = resw_r;
  assign out_error  = rese_r;

  `BCW_ASSERT_NOW(a_err_zero, out_valid && out_error, out_weight == '0, "error result with nonzero weight")
  `BCW_ASSERT_NOW(a_wt_range, out_valid, out_weight <= (WEIGHT_W'(1) << WT_STEPS), "weight above one")
  `BCW_ASSERT_NOW(a_from_busy, out_valid, $past(busy), "result without a query in progress")
  `BCW_ASSERT_NEXT(a_one_pulse, out_valid, !out_valid, "result strobe longer than one cycle")

endmodule
`default_nettype wire
